### src/indexed_shift_list_core_macros.svh
// ----------------------------------------------------------------------------
// indexed_shift_list_core assertion macros
// Shared concurrent assertion forms for the list core modules.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_LIST_CORE_MACROS_SVH
`define INDEXED_SHIFT_LIST_CORE_MACROS_SVH

// same-cycle implication
`define ISL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("isl assertion failed");

// next-cycle implication
`define ISL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("isl assertion failed");

`endif

### src/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg
// Transaction types, command and status codes, and the controller/datapath
// interface structs of the indexed shift list core.
// ----------------------------------------------------------------------------
`default_nettype none

package isl_pkg;

	localparam logic [3:0] CMD_READ   = 4'd0;
	localparam logic [3:0] CMD_WRITE  = 4'd1;
	localparam logic [3:0] CMD_INSERT = 4'd2;
	localparam logic [3:0] CMD_ERASE  = 4'd3;
	localparam logic [3:0] CMD_PUSH   = 4'd4;
	localparam logic [3:0] CMD_POP    = 4'd5;
	localparam logic [3:0] CMD_CLEAR  = 4'd6;
	localparam logic [3:0] CMD_RESIZE = 4'd7;
	localparam logic [3:0] CMD_ASSIGN = 4'd8;
	localparam logic [3:0] CMD_FRONT  = 4'd9;
	localparam logic [3:0] CMD_BACK   = 4'd10;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [3:0]         cmd;
		logic [5:0]         index;
		logic signed [31:0] value;
		logic [6:0]         count;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [6:0]         length;
		logic               is_empty;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [1:0] {
		RSEL_IDX,
		RSEL_ZERO,
		RSEL_LAST
	} rsel_t;

	typedef enum logic {
		WSEL_IDX,
		WSEL_CNT
	} wsel_t;

	typedef enum logic [1:0] {
		PSEL_CNT,
		PSEL_IDX,
		PSEL_ZERO
	} psel_t;

	typedef enum logic [2:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_ZERO,
		CNT_LOAD
	} cnt_op_t;

	typedef struct packed {
		logic       load_item;
		logic       rd_clear;
		logic       rd_capture;
		logic       st_load;
		logic [1:0] st_code;
		logic       rd_en;
		rsel_t      rsel;
		logic       wr_en;
		wsel_t      wsel;
		logic       ptr_load;
		psel_t      psel;
		logic       shift_step;
		logic       fill_step;
		cnt_op_t    cnt_op;
		logic       out_load;
	} ctl_t;

	typedef struct packed {
		logic [3:0] cmd;
		logic       idx_ge_cnt;
		logic       idx_gt_cnt;
		logic       cnt_full;
		logic       cnt_zero;
		logic       n_gt_cap;
		logic       shift_more;
		logic       pend;
		logic       fill_more;
	} stat_t;

endpackage

`default_nettype wire

### src/isl_ctrl.sv
// ----------------------------------------------------------------------------
// isl_ctrl
// Command sequencer: takes a transaction, checks it, steps the shift or fill
// loop and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_shift_list_core_macros.svh"

module isl_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_stall,
	output logic            rsp_valid,
	input  wire             rsp_stall,
	input  isl_pkg::stat_t  stat,
	output isl_pkg::ctl_t   ctl
);
	import isl_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHECK = 7'b0000010,
		S_READ  = 7'b0000100,
		S_SHIFT = 7'b0001000,
		S_FILL  = 7'b0010000,
		S_FINAL = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load_item = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_CHECK: begin
				ctl.rd_clear = 1'b1;
				ctl.st_load  = 1'b1;
				ctl.st_code  = ST_OK;
				state_d      = S_OUT;
				unique case (stat.cmd)
					CMD_READ: begin
						if (stat.idx_ge_cnt) begin
							ctl.st_code = ST_RANGE;
						end else begin
							ctl.rd_en = 1'b1;
							ctl.rsel  = RSEL_IDX;
							state_d   = S_READ;
						end
					end
					CMD_WRITE: begin
						if (stat.idx_ge_cnt) begin
							ctl.st_code = ST_RANGE;
						end else begin
							ctl.wr_en = 1'b1;
							ctl.wsel  = WSEL_IDX;
						end
					end
					CMD_INSERT: begin
						priority if (stat.idx_gt_cnt) begin
							ctl.st_code = ST_RANGE;
						end else if (stat.cnt_full) begin
							ctl.st_code = ST_FULL;
						end else begin
							ctl.ptr_load = 1'b1;
							ctl.psel     = PSEL_CNT;
							state_d      = S_SHIFT;
						end
					end
					CMD_ERASE: begin
						if (stat.idx_ge_cnt) begin
							ctl.st_code = ST_RANGE;
						end else begin
							ctl.ptr_load = 1'b1;
							ctl.psel     = PSEL_IDX;
							state_d      = S_SHIFT;
						end
					end
					CMD_PUSH: begin
						if (stat.cnt_full) begin
							ctl.st_code = ST_FULL;
						end else begin
							ctl.wr_en  = 1'b1;
							ctl.wsel   = WSEL_CNT;
							ctl.cnt_op = CNT_INC;
						end
					end
					CMD_POP: begin
						if (!stat.cnt_zero) begin
							ctl.cnt_op = CNT_DEC;
						end
					end
					CMD_CLEAR: begin
						ctl.cnt_op = CNT_ZERO;
					end
					CMD_RESIZE, CMD_ASSIGN: begin
						if (stat.n_gt_cap) begin
							ctl.st_code = ST_FULL;
						end else begin
							ctl.ptr_load = 1'b1;
							ctl.psel     = (stat.cmd == CMD_RESIZE) ? PSEL_CNT : PSEL_ZERO;
							state_d      = S_FILL;
						end
					end
					CMD_FRONT, CMD_BACK: begin
						if (stat.cnt_zero) begin
							ctl.st_code = ST_RANGE;
						end else begin
							ctl.rd_en = 1'b1;
							ctl.rsel  = (stat.cmd == CMD_FRONT) ? RSEL_ZERO : RSEL_LAST;
							state_d   = S_READ;
						end
					end
					default: begin
					end
				endcase
			end
			S_READ: begin
				ctl.rd_capture = 1'b1;
				state_d        = S_OUT;
			end
			S_SHIFT: begin
				ctl.shift_step = 1'b1;
				if (!stat.shift_more && !stat.pend) begin
					state_d = S_FINAL;
				end
			end
			S_FILL: begin
				ctl.fill_step = 1'b1;
				if (!stat.fill_more) begin
					ctl.cnt_op = CNT_LOAD;
					state_d    = S_OUT;
				end
			end
			S_FINAL: begin
				if (stat.cmd == CMD_INSERT) begin
					ctl.wr_en  = 1'b1;
					ctl.wsel   = WSEL_IDX;
					ctl.cnt_op = CNT_INC;
				end else begin
					ctl.cnt_op = CNT_DEC;
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`ISL_ASSERT_IMPLY(a_out_guard, clk, arst_n, ctl.out_load, (!rsp_valid_q || !rsp_stall))
	`ISL_ASSERT_IMPLY(a_rsp_rise, clk, arst_n, $rose(rsp_valid_q), $past(state_q == S_OUT))

endmodule

`default_nettype wire

### src/isl_dpath.sv
// ----------------------------------------------------------------------------
// isl_dpath
// Element store, element count, loop pointer, status flags and result
// register. Shifts move one element per cycle through the registered read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_shift_list_core_macros.svh"

module isl_dpath #(
	parameter int CAPACITY = 64
) (
	input  wire             clk,
	input  wire             arst_n,
	input  isl_pkg::req_t   req,
	input  isl_pkg::ctl_t   ctl,
	output isl_pkg::stat_t  stat,
	output isl_pkg::rsp_t   rsp
);
	import isl_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 7) ? CW : 7;

	logic [31:0]   mem [CAPACITY];

	logic [3:0]    cmd_q;
	logic [5:0]    idx_q;
	logic [31:0]   val_q;
	logic [6:0]    n_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;
	logic [AW-1:0] wa_q;
	logic          pend_q;
	logic [31:0]   rdata_q;
	logic [31:0]   rd_q;
	logic [1:0]    st_q;
	rsp_t          rsp_q;

	logic [XW-1:0] idx_x, cnt_x, n_x, ptr_x, cap_x;
	logic [CW-1:0] cnt_m1, src;
	logic          is_ins, shift_more, fill_more;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata;

	assign idx_x  = XW'(idx_q);
	assign cnt_x  = XW'(cnt_q);
	assign n_x    = XW'(n_q);
	assign ptr_x  = XW'(ptr_q);
	assign cap_x  = XW'(CAPACITY);
	assign cnt_m1 = cnt_q - CW'(1);
	assign is_ins = (cmd_q == CMD_INSERT);
	assign src    = is_ins ? (ptr_q - CW'(1)) : (ptr_q + CW'(1));

	assign shift_more = is_ins ? (ptr_x > idx_x) : ((ptr_x + XW'(1)) < cnt_x);
	assign fill_more  = (ptr_x < n_x);

	assign stat.cmd        = cmd_q;
	assign stat.idx_ge_cnt = (idx_x >= cnt_x);
	assign stat.idx_gt_cnt = (idx_x > cnt_x);
	assign stat.cnt_full   = (cnt_x >= cap_x);
	assign stat.cnt_zero   = (cnt_q == '0);
	assign stat.n_gt_cap   = (n_x > cap_x);
	assign stat.shift_more = shift_more;
	assign stat.pend       = pend_q;
	assign stat.fill_more  = fill_more;

	assign rsp = rsp_q;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = val_q;
		if (ctl.rd_en) begin
			re = 1'b1;
			unique case (ctl.rsel)
				RSEL_IDX:  raddr = idx_x[AW-1:0];
				RSEL_ZERO: raddr = '0;
				RSEL_LAST: raddr = cnt_m1[AW-1:0];
				default:   raddr = '0;
			endcase
		end
		if (ctl.wr_en) begin
			we    = 1'b1;
			waddr = (ctl.wsel == WSEL_CNT) ? cnt_q[AW-1:0] : idx_x[AW-1:0];
		end
		if (ctl.fill_step && fill_more) begin
			we    = 1'b1;
			waddr = ptr_q[AW-1:0];
		end
		if (ctl.shift_step) begin
			if (shift_more) begin
				re    = 1'b1;
				raddr = src[AW-1:0];
			end
			if (pend_q) begin
				we    = 1'b1;
				waddr = wa_q;
				wdata = rdata_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q <= req.cmd;
			idx_q <= req.index;
			val_q <= req.value;
			n_q   <= req.count;
		end
		if (ctl.shift_step && shift_more) begin
			wa_q <= ptr_q[AW-1:0];
		end
		if (ctl.rd_clear) begin
			rd_q <= '0;
		end else if (ctl.rd_capture) begin
			rd_q <= rdata_q;
		end
		if (ctl.st_load) begin
			st_q <= ctl.st_code;
		end
		if (ctl.out_load) begin
			rsp_q.read_value <= rd_q;
			rsp_q.length     <= cnt_x[6:0];
			rsp_q.is_empty   <= (cnt_q == '0);
			rsp_q.status     <= st_q;
		end
		if (ctl.ptr_load) begin
			unique case (ctl.psel)
				PSEL_CNT:  ptr_q <= cnt_q;
				PSEL_IDX:  ptr_q <= idx_x[CW-1:0];
				PSEL_ZERO: ptr_q <= '0;
				default:   ptr_q <= '0;
			endcase
		end else if (ctl.shift_step && shift_more) begin
			ptr_q <= src;
		end else if (ctl.fill_step && fill_more) begin
			ptr_q <= ptr_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			unique case (ctl.cnt_op)
				CNT_HOLD: cnt_q <= cnt_q;
				CNT_INC:  cnt_q <= cnt_q + CW'(1);
				CNT_DEC:  cnt_q <= cnt_m1;
				CNT_ZERO: cnt_q <= '0;
				CNT_LOAD: cnt_q <= n_x[CW-1:0];
				default:  cnt_q <= cnt_q;
			endcase
			if (ctl.ptr_load) begin
				pend_q <= 1'b0;
			end else if (ctl.shift_step) begin
				pend_q <= shift_more;
			end
		end
	end

	`ISL_ASSERT_IMPLY(a_cnt_cap, clk, arst_n, 1'b1, (cnt_x <= cap_x))
	`ISL_ASSERT_IMPLY(a_wr_range, clk, arst_n, we, (XW'(waddr) < cap_x))

endmodule

`default_nettype wire

### src/indexed_shift_list_core.sv
// Flow: a transaction is taken while idle, checked, then read, shifted or filled as needed
// before its result is loaded into the output register. Insert/erase move one element per
// cycle through the store's registered read port and write port; resize/assign write the
// filled entries in turn. A stalled output holds the result until the stall is released.
// One transaction in flight; the next is accepted in the cycle after the result
// is loaded into the output register. Reset clears the element count, not the store.
// ----------------------------------------------------------------------------
// indexed_shift_list_core
// Fixed-capacity list of signed 32-bit words with indexed access, insert,
// erase, push/pop, clear, resize and assign.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_shift_list_core #(
	parameter int CAPACITY = 64
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_stall,
	input  isl_pkg::req_t   req,
	output logic            rsp_valid,
	input  wire             rsp_stall,
	output isl_pkg::rsp_t   rsp
);
	import isl_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	isl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	isl_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
